// ===== sv/upd_pkg.sv =====
package upd_pkg;

	// Escape phase codes.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PCT  = 2'd1;
	localparam logic [1:0] PH_DIG  = 2'd2;

	// Character constants.
	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;

	// Most results that one request can cause.
	localparam int MAX_RES = 3;

	// Scanner state carried from one request to the next.
	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] first;
	} scan_t;

	// Group of results caused by one request.
	typedef struct packed {
		logic [1:0]                 cnt;
		logic [MAX_RES-1:0][7:0]    bytes;
		logic                       str_end;
	} grp_t;

	// Value of one hex digit; any other byte counts as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] b);
		logic [7:0] d;
		d = 8'h00;
		if (b >= CH_ZERO && b <= CH_ZERO + 8'd9) begin
			d = b - CH_ZERO;
		end else if (b >= CH_UPPER && b <= CH_UPPER + 8'd5) begin
			d = b - CH_UPPER + 8'd10;
		end else if (b >= CH_LOWER && b <= CH_LOWER + 8'd5) begin
			d = b - CH_LOWER + 8'd10;
		end
		return d[3:0];
	endfunction

endpackage

// ===== sv/upd_decode.sv =====
module upd_decode (
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  upd_pkg::scan_t cur,
	output upd_pkg::scan_t nxt,
	output upd_pkg::grp_t  grp
);
	import upd_pkg::*;

	logic [7:0] val;

	// Byte that the two gathered digits form.
	assign val = {hex_value(cur.first), hex_value(in_byte)};

	// Next scanner state and the results of this request.
	always_comb begin
		nxt.phase   = PH_IDLE;
		nxt.first   = cur.first;
		grp.cnt     = 2'd0;
		grp.bytes   = '0;
		grp.str_end = in_last;
		unique case (cur.phase)
			PH_PCT: begin
				nxt.first = in_byte;
				if (in_last) begin
					// Escape cut short after the first digit.
					grp.bytes[0] = PCT_CHAR;
					grp.bytes[1] = in_byte;
					grp.cnt      = 2'd2;
				end else begin
					nxt.phase = PH_DIG;
				end
			end
			PH_DIG: begin
				if (val >= PRINT_LO && val <= PRINT_HI) begin
					grp.bytes[0] = val;
					grp.cnt      = 2'd1;
				end else begin
					// Rejected escape passes through unchanged.
					grp.bytes[0] = PCT_CHAR;
					grp.bytes[1] = cur.first;
					grp.bytes[2] = in_byte;
					grp.cnt      = 2'd3;
				end
			end
			default: begin
				if (in_byte == PCT_CHAR && !in_last) begin
					nxt.phase = PH_PCT;
				end else begin
					grp.bytes[0] = in_byte;
					grp.cnt      = 2'd1;
				end
			end
		endcase
	end

endmodule

// ===== sv/upd_out_queue.sv =====
module upd_out_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  upd_pkg::grp_t  grp,
	output logic          load_ok,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          string_end
);
	import upd_pkg::*;

	logic [1:0]              cnt_s2;
	logic [1:0]              idx_s2;
	logic [MAX_RES-1:0][7:0] bytes_s2;
	logic                    end_s2;
	logic                    done;

	// Current result of the held group.
	assign out_valid  = (cnt_s2 != 2'd0);
	assign run_last   = (idx_s2 == cnt_s2 - 2'd1);
	assign string_end = run_last && end_s2;
	assign out_byte   = bytes_s2[idx_s2];

	// The group frees up when its final result is taken.
	assign done    = out_valid && !out_stall && run_last;
	assign load_ok = !out_valid || done;

	// Group count and index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
			idx_s2 <= 2'd0;
		end else if (load) begin
			cnt_s2 <= grp.cnt;
			idx_s2 <= 2'd0;
		end else if (done) begin
			cnt_s2 <= 2'd0;
			idx_s2 <= 2'd0;
		end else if (out_valid && !out_stall) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	// Group payload.
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= grp.bytes;
			end_s2   <= grp.str_end;
		end
	end

endmodule

// ===== sv/url_percent_decoder_unit.sv =====
// Flow: a request is accepted into the input register, then moves into the result
// register once that register can take its group; its first result is offered from there.
// Throughput: one request per cycle while the result register can take each group;
// a rejected escape holds it until its three results are taken, a cut-short escape until its two are.
// Results leave at one per cycle from the result register while out_stall is low.
// Reset: arst_n clears the escape phase, the stored digit and all valid flags.
module url_percent_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_end
);
	import upd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	scan_t      scan_q;
	scan_t      scan_nxt;
	grp_t       grp;
	logic       load_ok;
	logic       move;

	// The held request moves on once the result register can take its group.
	assign move     = valid_s1 && load_ok;
	assign in_stall = valid_s1 && !load_ok;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Scanner state advances with each request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '{phase: PH_IDLE, first: 8'h00};
		end else if (move) begin
			scan_q <= scan_nxt;
		end
	end

	upd_decode u_decode (
		.in_byte (byte_s1),
		.in_last (last_s1),
		.cur     (scan_q),
		.nxt     (scan_nxt),
		.grp     (grp)
	);

	upd_out_queue u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (move),
		.grp        (grp),
		.load_ok    (load_ok),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

// ===== sv/upd_checker.sv =====
module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       string_end
);
	import upd_pkg::*;

	// A stalled request stays offered and unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
		else $error("request changed while stalled");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// The end of the string is always the final result of its request.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> run_last)
		else $error("string end on a non-final result");

	// A group of several results keeps going once a result is taken.
	a_grp_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("result group cut short");

	// A group of several results that starts right after another group ends opens with the percent sign.
	a_grp_pct: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && run_last) ##1 (out_valid && !run_last)
		|-> out_byte == PCT_CHAR)
		else $error("multi-result group without leading percent");

endmodule

bind url_percent_decoder_unit upd_checker u_chk (.*);
